// File: rtl/core/long_fir_convolver_block_latency_top_assert.svh
// Assertion macros for the long FIR convolver.
// No dependencies; included by the top level only.
`ifndef LONG_FIR_CONVOLVER_BLOCK_LATENCY_TOP_ASSERT_SVH
`define LONG_FIR_CONVOLVER_BLOCK_LATENCY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfc assertion failed");
`define LFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfc assertion failed");
`else
`define LFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/lfc_pkg.sv
// Shared constants, types and codes of the long FIR convolver.
// No dependencies.
package lfc_pkg;

	localparam int MAX_TAPS    = 1024;
	localparam int PARTITION   = 128;
	localparam int SAMPLE_BITS = 24;

	localparam int HIST_DEPTH = MAX_TAPS + PARTITION;
	localparam int TAP_AW     = $clog2(MAX_TAPS);
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(MAX_TAPS + 1);
	localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
	localparam int PROD_W     = 2 * SAMPLE_BITS;
	localparam int ACC_W      = PROD_W + CNT_W - 1;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_LOAD   = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctrl_t;

endpackage

// File: rtl/core/lfc_if.sv
// Valid/ready channels of the long FIR convolver: request and response.
// Depends on lfc_pkg.
interface lfc_req_if;
	import lfc_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	sample_t             sample_in;
	logic [TAP_AW-1:0]   tap_index;
	sample_t             tap_value;

	modport source (output valid, req_type, sample_in, tap_index, tap_value, input ready);
	modport sink (input valid, req_type, sample_in, tap_index, tap_value, output ready);
endinterface

interface lfc_rsp_if;
	import lfc_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface

// File: rtl/core/lfc_mac.sv
// Shared multiply-accumulate unit with floor shift and saturation.
// Depends on lfc_pkg.
module lfc_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  lfc_pkg::mac_ctrl_t ctrl,
	input  lfc_pkg::sample_t   tap,
	input  lfc_pkg::sample_t   hist,
	output lfc_pkg::sample_t   result
);
	import lfc_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  shifted;
	logic [ACC_W-SAMPLE_BITS:0] upper;

	always_ff @(posedge clk) begin
		prod_s2 <= tap * hist;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s2 <= ctrl.valid;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end
		end
	end

	// arithmetic shift is floor division; saturate when the dropped top bits disagree
	always_comb begin
		shifted = acc_q >>> (SAMPLE_BITS - 1);
		upper   = shifted[ACC_W-1:SAMPLE_BITS-1];
		if ((&upper) || !(|upper)) begin
			result = shifted[SAMPLE_BITS-1:0];
		end else if (upper[ACC_W-SAMPLE_BITS]) begin
			result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

endmodule

// File: rtl/core/long_fir_convolver_block_latency_top.sv
// Long FIR convolver, direct form with one shared MAC walked over the taps.
// A sample is taken only in idle; the MAC then walks taps = min(tap_count, 1024) taps, and the result
// is registered to rsp before the next request (sample or tap load) is taken.
// The serial walk is set by the single MAC and the one read port of each store.
// Reset: async active low; no clearing pass, a fill count makes unwritten history read as zero.
// Depends on lfc_pkg, lfc_if, lfc_mac and the assertion macro header.
module long_fir_convolver_block_latency_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tap_count_we,
	input  logic [lfc_pkg::CNT_W-1:0] tap_count_wdata,
	lfc_req_if.sink                   req,
	lfc_rsp_if.source                 rsp
);
	import lfc_pkg::*;

	`include "long_fir_convolver_block_latency_top_assert.svh"

	sample_t tap_mem [MAX_TAPS];
	sample_t hist_mem [HIST_DEPTH];

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     tap_count_q;
	logic [CNT_W-1:0]     taps_q;
	logic [CNT_W-1:0]     taps_lim;
	logic [CNT_W-1:0]     k_q;
	logic [HIST_AW-1:0]   ptr_q;
	logic [HIST_AW-1:0]   idx_q;
	logic [HIST_AW-1:0]   idx_start;
	logic [FILL_W-1:0]    fill_q;
	logic                 drain_q;
	logic                 issue_s1;
	logic                 hist_ok_s1;
	sample_t              tap_rd_s1;
	sample_t              hist_rd_s1;
	sample_t              hist_op;
	sample_t              mac_result;
	sample_t              sample_out_q;
	logic                 out_valid_q;
	mac_ctrl_t            mac_ctrl;

	logic accept;
	logic accept_sample;
	logic accept_load;
	logic issue;
	logic load_out;

	assign accept        = req.valid && req.ready;
	assign accept_sample = accept && (req.req_type == REQ_SAMPLE);
	assign accept_load   = accept && (req.req_type == REQ_LOAD);

	assign taps_lim = (tap_count_q > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : tap_count_q;

	// tap 0 of this output reads the slot PARTITION slots behind the one just written; later taps go further back
	assign idx_start = (ptr_q >= HIST_AW'(PARTITION)) ? ptr_q - HIST_AW'(PARTITION)
	                                                  : ptr_q + HIST_AW'(HIST_DEPTH - PARTITION);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (accept_sample) begin
					state_d = (taps_lim == '0) ? ST_DRAIN : ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (k_q == taps_q - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= CNT_W'(1);
			taps_q      <= '0;
			k_q         <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			fill_q      <= '0;
			drain_q     <= 1'b0;
			issue_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tap_count_we) begin
				tap_count_q <= tap_count_wdata;
			end
			issue_s1 <= issue;
			if (accept_sample) begin
				taps_q  <= taps_lim;
				k_q     <= '0;
				idx_q   <= idx_start;
				drain_q <= 1'b0;
				ptr_q   <= (ptr_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				if (fill_q != FILL_W'(HIST_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (issue) begin
				k_q   <= k_q + 1'b1;
				idx_q <= (idx_q == '0) ? HIST_AW'(HIST_DEPTH - 1) : idx_q - 1'b1;
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tap store: written by load transactions, read once per MAC step
	always_ff @(posedge clk) begin
		if (accept_load) begin
			tap_mem[req.tap_index] <= req.tap_value;
		end
		tap_rd_s1 <= tap_mem[k_q[TAP_AW-1:0]];
	end

	// sample history ring
	always_ff @(posedge clk) begin
		if (accept_sample) begin
			hist_mem[ptr_q] <= req.sample_in;
		end
		hist_rd_s1 <= hist_mem[idx_q];
		hist_ok_s1 <= (FILL_W'(idx_q) < fill_q);
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_out_q <= mac_result;
		end
	end

	assign hist_op        = hist_ok_s1 ? hist_rd_s1 : '0;
	assign mac_ctrl.clear = accept_sample;
	assign mac_ctrl.valid = issue_s1;

	lfc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.tap    (tap_rd_s1),
		.hist   (hist_op),
		.result (mac_result)
	);

	assign rsp.valid      = out_valid_q;
	assign rsp.sample_out = sample_out_q;

	`LFC_ASSERT_IMPL(a_tap_in_range, clk, arst_n, state_q == ST_RUN, k_q < taps_q)
	`LFC_ASSERT_IMPL(a_idle_no_issue, clk, arst_n, state_q == ST_IDLE, !issue_s1)
	`LFC_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_W'(HIST_DEPTH))
	`LFC_ASSERT_NEXT(a_done_loads, clk, arst_n, load_out, rsp.valid && state_q == ST_IDLE)

endmodule
